// ----- rtl/core/mrtb_pkg.sv -----
package mrtb_pkg;

    localparam int DEF_NUM_TRANSFORMS = 4;
    localparam int DEF_COORD_WIDTH    = 32;

    localparam int DATA_W   = 32;
    localparam int ROW_LEN  = 4;
    localparam int MAT_LEN  = 12;
    localparam int NUM_AXES = 3;
    localparam int MAX_LANES = 4;

    // Arithmetic widths of one lane and of the merge.
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int SH_W    = PROD_W - FRAC_W;
    localparam int D_W     = SH_W + 3;
    localparam int DLO_W   = 24;
    localparam int DHI_W   = D_W - DLO_W;
    localparam int HI_W    = DHI_W + DATA_W;
    localparam int LO_W    = DLO_W + 1 + DATA_W;
    localparam int FULL_W  = D_W + DATA_W;
    localparam int TERM_W  = FULL_W - FRAC_W;
    localparam int ACC_W   = TERM_W + 3;
    localparam int LANE_LAT = 4;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_POINT = 1'b1;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] axis;
    } tag_t;

    typedef struct packed {
        logic               req_type;
        logic [1:0]         slot;
        logic [3:0]         entry;
        logic signed [31:0] coef_value;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] weight_0;
        logic signed [31:0] weight_1;
        logic signed [31:0] weight_2;
        logic signed [31:0] weight_3;
    } in_t;

    typedef struct packed {
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] qz;
        logic               overflow;
    } out_t;

    typedef struct packed {
        tag_t               tag;
        logic signed [31:0] value;
        logic               sat;
    } res_t;

endpackage

// ----- rtl/core/masked_rigid_transform_blend.sv -----
// Blends a point through up to four stored 3x4 rigid transforms, one lane per
// transform. A coefficient load gives no result. For a point, the three axes
// enter the lanes in turn (X, Y, Z) from the issue state; each lane is four
// stages deep (row products, offset, split weight products, shift), the merge
// adds two more, the done register marks the point finished once the last axis
// leaves the merge, and the output register is loaded at handoff. A new beat is
// taken only after the previous point's result has been handed to the output
// register, so no point is accepted while another is still in flight. Input is
// also held off while a finished result waits behind an output register that is
// still full. The transform table is all zero after reset.
module masked_rigid_transform_blend
    import mrtb_pkg::*;
#(
    parameter int NUM_TRANSFORMS = DEF_NUM_TRANSFORMS,
    parameter int COORD_WIDTH    = DEF_COORD_WIDTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_t        in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_t       out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_data
);

    state_t state_reg;
    state_t state_next;
    logic [1:0] axis_reg;
    logic [1:0] axis_next;
    logic [2:0] active_reg;

    logic signed [DATA_W-1:0] table_reg [NUM_TRANSFORMS][MAT_LEN];
    logic signed [DATA_W-1:0] p_reg [NUM_AXES];
    logic signed [DATA_W-1:0] w_reg [MAX_LANES];

    tag_t issue;
    tag_t tag_pipe_reg [LANE_LAT];
    res_t res;

    logic signed [DATA_W-1:0] row   [NUM_TRANSFORMS][ROW_LEN];
    logic signed [TERM_W-1:0] terms [NUM_TRANSFORMS];
    logic signed [DATA_W-1:0] pa_issue;
    logic signed [DATA_W-1:0] pa_merge;
    logic [NUM_TRANSFORMS-1:0] lane_en;

    logic signed [DATA_W-1:0] res_reg [NUM_AXES];
    logic sat_reg;
    logic done_reg;
    logic out_valid_reg;
    out_t out_reg;

    logic in_fire;
    logic handoff;

    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_data.req_type == REQ_POINT)
                begin
                    state_next = ST_ISSUE;
                    axis_next  = AXIS_X;
                end
            end
            ST_ISSUE:
            begin
                if (axis_reg == AXIS_Z)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            ST_WAIT:
            begin
                if (handoff)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_stall    = 1'b1;
        issue.valid = 1'b0;
        issue.axis  = axis_reg;
        handoff     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_ISSUE:
            begin
                issue.valid = 1'b1;
            end
            ST_WAIT:
            begin
                handoff = done_reg && (!out_valid_reg || !out_stall);
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            axis_reg   <= AXIS_X;
            active_reg <= 3'd4;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            if (cfg_valid && cfg_ready)
            begin
                active_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_TRANSFORMS; s++)
            begin
                for (int e = 0; e < MAT_LEN; e++)
                begin
                    table_reg[s][e] <= '0;
                end
            end
        end
        else if (in_fire && in_data.req_type == REQ_LOAD)
        begin
            for (int s = 0; s < NUM_TRANSFORMS; s++)
            begin
                for (int e = 0; e < MAT_LEN; e++)
                begin
                    if (in_data.slot == 2'(s) && in_data.entry == 4'(e))
                    begin
                        table_reg[s][e] <= in_data.coef_value;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && in_data.req_type == REQ_POINT)
        begin
            p_reg[0] <= in_data.px;
            p_reg[1] <= in_data.py;
            p_reg[2] <= in_data.pz;
            w_reg[0] <= in_data.weight_0;
            w_reg[1] <= in_data.weight_1;
            w_reg[2] <= in_data.weight_2;
            w_reg[3] <= in_data.weight_3;
        end
    end

    // Row of each transform for the axis being issued.
    always_comb
    begin
        for (int k = 0; k < NUM_TRANSFORMS; k++)
        begin
            for (int j = 0; j < ROW_LEN; j++)
            begin
                case (axis_reg)
                    AXIS_X:  row[k][j] = table_reg[k][j];
                    AXIS_Y:  row[k][j] = table_reg[k][ROW_LEN + j];
                    default: row[k][j] = table_reg[k][2 * ROW_LEN + j];
                endcase
            end
        end
        case (axis_reg)
            AXIS_X:  pa_issue = p_reg[0];
            AXIS_Y:  pa_issue = p_reg[1];
            default: pa_issue = p_reg[2];
        endcase
        case (tag_pipe_reg[LANE_LAT-1].axis)
            AXIS_X:  pa_merge = p_reg[0];
            AXIS_Y:  pa_merge = p_reg[1];
            default: pa_merge = p_reg[2];
        endcase
    end

    // Active counts above the lane count use every lane.
    always_comb
    begin
        for (int k = 0; k < NUM_TRANSFORMS; k++)
        begin
            lane_en[k] = (active_reg > 3'(k));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_LAT; i++)
            begin
                tag_pipe_reg[i] <= '0;
            end
        end
        else
        begin
            tag_pipe_reg[0] <= issue;
            for (int i = 1; i < LANE_LAT; i++)
            begin
                tag_pipe_reg[i] <= tag_pipe_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < NUM_TRANSFORMS; k++)
    begin : g_lane
        mrtb_lane u_lane (
            .clk  (clk),
            .row  (row[k]),
            .px   (p_reg[0]),
            .py   (p_reg[1]),
            .pz   (p_reg[2]),
            .pa   (pa_issue),
            .w    (w_reg[k]),
            .term (terms[k])
        );
    end

    mrtb_merge #(
        .NUM_TRANSFORMS (NUM_TRANSFORMS),
        .COORD_WIDTH    (COORD_WIDTH)
    ) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag     (tag_pipe_reg[LANE_LAT-1]),
        .terms   (terms),
        .lane_en (lane_en),
        .pa      (pa_merge),
        .res     (res)
    );

    always_ff @(posedge clk)
    begin
        if (res.tag.valid)
        begin
            case (res.tag.axis)
                AXIS_X:  res_reg[0] <= res.value;
                AXIS_Y:  res_reg[1] <= res.value;
                default: res_reg[2] <= res.value;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                sat_reg <= 1'b0;
            end
            else if (res.tag.valid)
            begin
                sat_reg <= sat_reg | res.sat;
            end
            if (handoff)
            begin
                done_reg <= 1'b0;
            end
            else if (res.tag.valid && res.tag.axis == AXIS_Z)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (handoff)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (handoff)
        begin
            out_reg.qx       <= res_reg[0];
            out_reg.qy       <= res_reg[1];
            out_reg.qz       <= res_reg[2];
            out_reg.overflow <= sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A finished point is only ever waiting in the wait state.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == ST_WAIT)
        else $error("result collected outside the wait state");

    // Lane results arrive only while a point is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.tag.valid |-> (state_reg == ST_WAIT || state_reg == ST_ISSUE))
        else $error("merge result with no point in flight");

    // An accepted point starts issuing at the first axis.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.req_type == REQ_POINT)
            |=> (state_reg == ST_ISSUE && axis_reg == AXIS_X))
        else $error("point accepted without starting the axis sequence");

endmodule

// ----- rtl/core/mrtb_lane.sv -----
module mrtb_lane
    import mrtb_pkg::*;
(
    input  logic                     clk,
    input  logic signed [DATA_W-1:0] row [ROW_LEN],
    input  logic signed [DATA_W-1:0] px,
    input  logic signed [DATA_W-1:0] py,
    input  logic signed [DATA_W-1:0] pz,
    input  logic signed [DATA_W-1:0] pa,
    input  logic signed [DATA_W-1:0] w,
    output logic signed [TERM_W-1:0] term
);

    logic signed [PROD_W-1:0] prod_reg [NUM_AXES];
    logic signed [DATA_W-1:0] t_reg;
    logic signed [DATA_W-1:0] pa_reg;
    logic signed [D_W-1:0]    d_reg;
    logic signed [D_W-1:0]    d_next;
    logic signed [HI_W-1:0]   hi_reg;
    logic signed [LO_W-1:0]   lo_reg;
    logic signed [FULL_W-1:0] full_next;
    logic signed [TERM_W-1:0] term_reg;

    // Rotation products; the translation and point coordinate ride along.
    always_ff @(posedge clk)
    begin
        prod_reg[0] <= row[0] * px;
        prod_reg[1] <= row[1] * py;
        prod_reg[2] <= row[2] * pz;
        t_reg       <= row[3];
        pa_reg      <= pa;
    end

    always_comb
    begin
        d_next = {{3{prod_reg[0][PROD_W-1]}}, prod_reg[0][PROD_W-1:FRAC_W]}
               + {{3{prod_reg[1][PROD_W-1]}}, prod_reg[1][PROD_W-1:FRAC_W]}
               + {{3{prod_reg[2][PROD_W-1]}}, prod_reg[2][PROD_W-1:FRAC_W]}
               + {{(D_W-DATA_W){t_reg[DATA_W-1]}}, t_reg}
               - {{(D_W-DATA_W){pa_reg[DATA_W-1]}}, pa_reg};
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    // The weight product is split into two partial products of the offset.
    always_ff @(posedge clk)
    begin
        hi_reg <= $signed(d_reg[D_W-1:DLO_W]) * w;
        lo_reg <= $signed({1'b0, d_reg[DLO_W-1:0]}) * w;
    end

    always_comb
    begin
        full_next = $signed({hi_reg, {DLO_W{1'b0}}})
                  + $signed({{(FULL_W-LO_W){lo_reg[LO_W-1]}}, lo_reg});
    end

    always_ff @(posedge clk)
    begin
        term_reg <= full_next[FULL_W-1:FRAC_W];
    end

    assign term = term_reg;

endmodule

// ----- rtl/core/mrtb_merge.sv -----
module mrtb_merge
    import mrtb_pkg::*;
#(
    parameter int NUM_TRANSFORMS = DEF_NUM_TRANSFORMS,
    parameter int COORD_WIDTH    = DEF_COORD_WIDTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  tag_t                     tag,
    input  logic signed [TERM_W-1:0] terms [NUM_TRANSFORMS],
    input  logic [NUM_TRANSFORMS-1:0] lane_en,
    input  logic signed [DATA_W-1:0] pa,
    output res_t                     res
);

    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

    tag_t                    tag1_reg;
    tag_t                    tag2_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                    sat_reg;
    logic                    sat_next;

    always_comb
    begin
        acc_next = {{(ACC_W-DATA_W){pa[DATA_W-1]}}, pa};
        for (int k = 0; k < NUM_TRANSFORMS; k++)
        begin
            if (lane_en[k])
            begin
                acc_next = acc_next
                         + {{(ACC_W-TERM_W){terms[k][TERM_W-1]}}, terms[k]};
            end
        end
    end

    always_comb
    begin
        if (acc_reg > SAT_MAX)
        begin
            value_next = SAT_MAX[DATA_W-1:0];
            sat_next   = 1'b1;
        end
        else if (acc_reg < SAT_MIN)
        begin
            value_next = SAT_MIN[DATA_W-1:0];
            sat_next   = 1'b1;
        end
        else
        begin
            value_next = acc_reg[DATA_W-1:0];
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag;
            tag2_reg <= tag1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        value_reg <= value_next;
        sat_reg   <= sat_next;
    end

    assign res.tag   = tag2_reg;
    assign res.value = value_reg;
    assign res.sat   = sat_reg;

endmodule

// ----- bench/blend_checker.sv -----
`timescale 1ns / 100ps

module blend_checker
    import mrtb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  in_t        in_data,
    input  logic       out_valid,
    input  logic       out_stall,
    input  out_t       out_data,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [2:0] cfg_data,
    output int         fail_count,
    output int         pending
);

    logic [31:0] coef_table [0:47];
    logic [2:0]  active_count;
    out_t        blend_queue [$];

    function automatic out_t blend_point(in_t pt);
        out_t r;
        logic signed [63:0]  p [3];
        logic signed [63:0]  w [4];
        logic signed [63:0]  d;
        logic signed [63:0]  prod;
        logic signed [127:0] acc;
        logic signed [127:0] term;
        logic signed [31:0]  q [3];
        int n;
        r = '0;
        p[0] = 64'(pt.px);
        p[1] = 64'(pt.py);
        p[2] = 64'(pt.pz);
        w[0] = 64'(pt.weight_0);
        w[1] = 64'(pt.weight_1);
        w[2] = 64'(pt.weight_2);
        w[3] = 64'(pt.weight_3);
        n = (active_count > 3'd4) ? 4 : int'(active_count);
        for (int a = 0; a < 3; a++)
        begin
            acc = 128'(p[a]);
            for (int k = 0; k < n; k++)
            begin
                d = 64'sd0;
                for (int j = 0; j < 3; j++)
                begin
                    prod = 64'($signed(coef_table[k*12 + a*4 + j])) * p[j];
                    d = d + (prod >>> 16);
                end
                d = d + 64'($signed(coef_table[k*12 + a*4 + 3])) - p[a];
                term = 128'(signed'(d)) * 128'(signed'(w[k]));
                acc = acc + (term >>> 16);
            end
            if (acc > 128'sd2147483647)
            begin
                q[a] = 32'sh7fffffff;
                r.overflow = 1'b1;
            end
            else if (acc < -128'sd2147483648)
            begin
                q[a] = 32'sh80000000;
                r.overflow = 1'b1;
            end
            else
                q[a] = acc[31:0];
        end
        r.qx = q[0];
        r.qy = q[1];
        r.qz = q[2];
        return r;
    endfunction

    assign pending = blend_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_t exp_r;
        if (!rst_n)
        begin
            for (int i = 0; i < 48; i++)
                coef_table[i] = '0;
            active_count = 3'd4;
            blend_queue.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                active_count = cfg_data;
            if (out_valid && !out_stall)
            begin
                if (blend_queue.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, out_data);
                    fail_count++;
                end
                else
                begin
                    exp_r = blend_queue.pop_front();
                    if (exp_r.qx !== out_data.qx || exp_r.qy !== out_data.qy ||
                        exp_r.qz !== out_data.qz || exp_r.overflow !== out_data.overflow)
                    begin
                        $display("%0t: mismatch expected %h %h %h %b actual %h %h %h %b",
                                 $time, exp_r.qx, exp_r.qy, exp_r.qz, exp_r.overflow,
                                 out_data.qx, out_data.qy, out_data.qz, out_data.overflow);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (in_data.req_type == REQ_LOAD)
                begin
                    if (in_data.entry < MAT_LEN)
                        coef_table[in_data.slot*12 + in_data.entry] = in_data.coef_value;
                end
                else
                    blend_queue.push_back(blend_point(in_data));
            end
        end
    end

endmodule

// ----- bench/tb_masked_rigid_transform_blend.sv -----
`timescale 1ns / 100ps

module tb_masked_rigid_transform_blend;
    import mrtb_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_t        in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_t       out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_data = '0;
    int         fail_count;
    int         pending;
    int         send_idle = 0;
    int         recv_idle = 0;
    int         hold_cycles = 0;
    logic       hold_req = 1'b0;
    logic       hold_taken = 1'b0;
    int         cycle_count = 0;

    always #2 clk = ~clk;

    masked_rigid_transform_blend DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    blend_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    // Receiver: random stall, or a long forced hold-off.
    always @(negedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_cycles = 300;
        end
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h00010000;
            3: return 32'hffff0000;
            4: return 32'h0;
            5: return $urandom_range(32'h3ffff) - 32'h20000;
            default: return $urandom;
        endcase
    endfunction

    // The beat stays valid after acceptance until the next beat or an idle cycle.
    task automatic send_beat(in_t beat);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_load(logic [1:0] s, logic [3:0] e, logic [31:0] v);
        in_t b;
        logic [287:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom};
        b = raw[$bits(in_t)-1:0];
        b.req_type = REQ_LOAD;
        b.slot = s;
        b.entry = e;
        b.coef_value = v;
        send_beat(b);
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit rnd_w);
        in_t b;
        logic [287:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom};
        b = raw[$bits(in_t)-1:0];
        b.req_type = REQ_POINT;
        b.px = x;
        b.py = y;
        b.pz = z;
        if (!rnd_w)
        begin
            b.weight_0 = 32'h00010000;
            b.weight_1 = 32'h00008000;
            b.weight_2 = 32'h7fffffff;
            b.weight_3 = 32'h80000000;
        end
        else
        begin
            b.weight_0 = pick_value();
            b.weight_1 = pick_value();
            b.weight_2 = pick_value();
            b.weight_3 = pick_value();
        end
        send_beat(b);
    endtask

    task automatic drain_and_config(logic [2:0] v);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [2:0] cfg_list [6];
        cfg_list = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd2, 3'd3};
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: a point against the all-zero table, then identity transforms.
        send_point(32'h7fffffff, 32'h80000000, 32'h0, 1'b0);
        for (int s = 0; s < 4; s++)
            for (int e = 0; e < 12; e += 5)
                send_load(2'(s), 4'(e), 32'h00010000);
        send_load(2'd1, 4'd3, 32'h7fffffff);
        send_load(2'd2, 4'd11, 32'h80000000);
        send_load(2'd0, 4'd15, 32'h7fffffff);
        send_load(2'd3, 4'd12, 32'h12345678);
        send_point(32'h00010000, 32'hffff0000, 32'h7fffffff, 1'b0);
        send_point(32'h80000000, 32'h80000000, 32'h80000000, 1'b1);
        send_point(32'h0, 32'h0, 32'h0, 1'b1);

        for (int phase = 0; phase < 6; phase++)
        begin
            drain_and_config(cfg_list[phase]);
            send_idle = (phase < 2) ? 16 : (phase < 4) ? 82 : 0;
            recv_idle = (phase < 2) ? 82 : (phase < 4) ? 16 : 0;
            if (phase == 4)
                hold_req = 1'b1;
            for (int i = 0; i < 140; i++)
            begin
                if ($urandom_range(3) == 0)
                    send_load(2'($urandom_range(3)), 4'($urandom_range(15)), pick_value());
                else
                    send_point(pick_value(), pick_value(), pick_value(), 1'b1);
            end
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
